/* design/wlbo_pkg.sv */
// shared types and constants of the window-level and box-overlay core
package wlbo_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_MIN     = 3'd0,
    CFG_WINDOW_GAIN    = 3'd1,
    CFG_SLICE_Z        = 3'd2,
    CFG_BOX_COUNT      = 3'd3,
    CFG_OVERLAY_ENABLE = 3'd4
  } cfg_reg_e;

  localparam int unsigned CFG_DATA_W = 32;

  // request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // outline color and gray limits
  localparam logic [7:0] HIT_RED   = 8'd255;
  localparam logic [7:0] HIT_GREEN = 8'd40;
  localparam logic [7:0] HIT_BLUE  = 8'd40;
  localparam logic [7:0] GRAY_MAX  = 8'd255;

  // half of one Q16 step, for rounding
  localparam logic [47:0] ROUND_HALF = 48'd32768;

  // input word
  typedef struct packed {
    logic              req_type;
    logic signed [15:0] hu;
    logic [11:0]       pix_x;
    logic [11:0]       pix_y;
    logic [3:0]        box_index;
    logic signed [15:0] box_x0;
    logic signed [15:0] box_y0;
    logic signed [15:0] box_x1;
    logic signed [15:0] box_y1;
    logic signed [15:0] box_z0;
    logic signed [15:0] box_z1;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       outline_hit;
  } out_word_t;

  // one stored box
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic signed [15:0] first_slice;
    logic signed [15:0] last_slice;
  } box_t;

endpackage

/* design/window_level_box_overlay_core.sv */
// CT window-level to RGB with bounding-box outline overlay, top level
//
// Usage: one input channel (in_valid_i / in_stall_o / in_word_i) takes two
// kinds of word. A load word (req_type 1) writes one box slot of the table
// and yields no output. A pixel word (req_type 0) yields exactly one RGB word
// on the output channel (out_valid_o / out_stall_i / out_word_o): the
// window-leveled gray in all channels, or red outline color when overlay is
// on and the pixel lies on the edge of an active box covering slice_z.
// Throughput is one word per clock while the output word is not held; a
// word can enter in every cycle in which the pipeline advances.
// The four register stages are input capture, the parallel box compares and
// window offset, the 16x32 gain multiply, and round, clamp and color select.
// A stalled output word freezes the whole pipeline, so in_stall_o rises in
// the same cycle and nothing is dropped or repeated.
// Reset clears the valid bits and the configuration registers (gain to
// 16320); the box table is not cleared, so a slot must be loaded before
// box_count includes it. Write configuration through cfg_we_i / cfg_index_i /
// cfg_wdata_i only while no pixel is in flight; the core does not enforce it.
module window_level_box_overlay_core
  import wlbo_pkg::*;
#(
  parameter int unsigned MAX_BOXES     = 16,
  parameter int unsigned MAX_IMAGE_DIM = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_word_t               in_word_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_word_t              out_word_o
);

  // configuration registers
  logic signed [15:0] window_min_q;
  logic [31:0]        window_gain_q;
  logic [11:0]        slice_z_q;
  logic [4:0]         box_count_q;
  logic               overlay_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_min_q     <= 16'sd0;
      window_gain_q    <= 32'd16320;
      slice_z_q        <= 12'd0;
      box_count_q      <= 5'd0;
      overlay_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_MIN:     window_min_q     <= $signed(cfg_wdata_i[15:0]);
        CFG_WINDOW_GAIN:    window_gain_q    <= cfg_wdata_i;
        CFG_SLICE_Z:        slice_z_q        <= cfg_wdata_i[11:0];
        CFG_BOX_COUNT:      box_count_q      <= cfg_wdata_i[4:0];
        CFG_OVERLAY_ENABLE: overlay_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless the output word is held
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  logic in_acc;
  assign in_acc = in_valid_i && adv;

  // box table, written by load words at acceptance
  box_t box_q [MAX_BOXES];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(MAX_BOXES); i++) begin
      if (in_acc && (in_word_i.req_type == REQ_LOAD) &&
          (int'(in_word_i.box_index) == i)) begin
        box_q[i].left        <= in_word_i.box_x0;
        box_q[i].top         <= in_word_i.box_y0;
        box_q[i].right       <= in_word_i.box_x1;
        box_q[i].bottom      <= in_word_i.box_y1;
        box_q[i].first_slice <= in_word_i.box_z0;
        box_q[i].last_slice  <= in_word_i.box_z1;
      end
    end
  end

  // stage 1: capture pixel words
  logic               s1_valid_q;
  logic signed [15:0] s1_hu_q;
  logic [11:0]        s1_x_q;
  logic [11:0]        s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i && (in_word_i.req_type == REQ_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_hu_q <= in_word_i.hu;
      s1_x_q  <= in_word_i.pix_x;
      s1_y_q  <= in_word_i.pix_y;
    end
  end

  // stage 2: per-box outline tests and window offset
  logic signed [16:0]    px_s;
  logic signed [16:0]    py_s;
  logic signed [16:0]    pz_s;
  logic                  in_image;
  logic [MAX_BOXES-1:0]  hit_d;
  logic signed [16:0]    diff_s;
  logic                  pos_d;

  assign px_s     = $signed({5'd0, s1_x_q});
  assign py_s     = $signed({5'd0, s1_y_q});
  assign pz_s     = $signed({5'd0, slice_z_q});
  assign in_image = ({5'd0, s1_x_q} < 17'(MAX_IMAGE_DIM)) &&
                    ({5'd0, s1_y_q} < 17'(MAX_IMAGE_DIM));

  always_comb begin
    for (int i = 0; i < int'(MAX_BOXES); i++) begin
      logic signed [16:0] x0, y0, x1, y1, z0, z1;
      logic in_z, on_h, on_v;
      x0 = 17'(box_q[i].left);
      y0 = 17'(box_q[i].top);
      x1 = 17'(box_q[i].right);
      y1 = 17'(box_q[i].bottom);
      z0 = 17'(box_q[i].first_slice);
      z1 = 17'(box_q[i].last_slice);
      in_z = (pz_s >= z0) && (pz_s <= z1);
      on_h = (px_s >= x0) && (px_s <= x1) && ((py_s == y0) || (py_s == y1));
      on_v = (py_s >= y0) && (py_s <= y1) && ((px_s == x0) || (px_s == x1));
      hit_d[i] = overlay_enable_q && in_image && (int'(box_count_q) > i) &&
                 in_z && (on_h || on_v);
    end
  end

  assign diff_s = 17'(s1_hu_q) - 17'(window_min_q);
  assign pos_d  = !diff_s[16] && (diff_s[15:0] != 16'd0);

  logic                 s2_valid_q;
  logic [MAX_BOXES-1:0] s2_hit_q;
  logic [15:0]          s2_diff_q;
  logic                 s2_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_hit_q  <= hit_d;
      s2_diff_q <= diff_s[15:0];
      s2_pos_q  <= pos_d;
    end
  end

  // stage 3: gain multiply and hit reduction
  logic        s3_valid_q;
  logic [47:0] s3_prod_q;
  logic        s3_pos_q;
  logic        s3_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_prod_q <= 48'(s2_diff_q) * 48'(window_gain_q);
      s3_pos_q  <= s2_pos_q;
      s3_hit_q  <= |s2_hit_q;
    end
  end

  // stage 4: round, clamp and pick the color
  logic [47:0] rounded;
  logic [31:0] level;
  logic [7:0]  gray;
  out_word_t   out_word_d;
  out_word_t   out_word_q;

  assign rounded = s3_prod_q + ROUND_HALF;
  assign level   = rounded[47:16];

  always_comb begin
    if (!s3_pos_q) begin
      gray = 8'd0;
    end else if (level > 32'(GRAY_MAX)) begin
      gray = GRAY_MAX;
    end else begin
      gray = level[7:0];
    end
    if (s3_hit_q) begin
      out_word_d.red         = HIT_RED;
      out_word_d.green       = HIT_GREEN;
      out_word_d.blue        = HIT_BLUE;
      out_word_d.outline_hit = 1'b1;
    end else begin
      out_word_d.red         = gray;
      out_word_d.green       = gray;
      out_word_d.blue        = gray;
      out_word_d.outline_hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* tb/tb_window_level_box_overlay_core.sv */
// self-checking testbench for the window-level and box-overlay core
module tb_window_level_box_overlay_core;
  import wlbo_pkg::*;

  localparam int unsigned MAX_BOXES     = 16;
  localparam int unsigned MAX_IMAGE_DIM = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int LONG_HOLD     = 60;
  localparam int SHOWN_ERRORS  = 10;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  in_word_t               in_word;
  logic                   out_valid;
  logic                   out_stall;
  out_word_t              out_word;

  // shadow copy of the configuration and the box table
  logic signed [15:0] win_min     = '0;
  logic [31:0]        win_gain    = 32'd16320;
  logic [11:0]        cur_slice   = '0;
  logic [4:0]         box_limit   = '0;
  logic               overlay_on  = 1'b0;
  box_t               box_table [MAX_BOXES];
  int                 window_span = 1000;

  out_word_t rgb_due [$];
  out_word_t want_rgb;
  int        error_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        long_hold_req = 1'b0;

  window_level_box_overlay_core #(
    .MAX_BOXES    (MAX_BOXES),
    .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // window-leveled gray with rounding and clamping
  function automatic logic [7:0] gray_level(logic signed [15:0] hu);
    int d;
    longint unsigned span, scale, prod;
    d = int'(hu) - int'(win_min);
    if (d <= 0) return 8'd0;
    span  = d;
    scale = win_gain;
    prod  = (span * scale + 64'd32768) >> 16;
    return (prod > 64'd255) ? GRAY_MAX : prod[7:0];
  endfunction

  // inclusive outline test, inverted bounds follow the same rule
  function automatic bit on_box_edge(box_t b, int x, int y);
    int x0, y0, x1, y1;
    x0 = b.left;
    y0 = b.top;
    x1 = b.right;
    y1 = b.bottom;
    return (x >= x0 && x <= x1 && (y == y0 || y == y1)) ||
           (y >= y0 && y <= y1 && (x == x0 || x == x1));
  endfunction

  // color of one pixel word under the current settings
  function automatic out_word_t shade_pixel(in_word_t w);
    out_word_t rgb;
    logic [7:0] g;
    int n, i, z, z0, z1;
    bit hit;
    g = gray_level(w.hu);
    hit = 1'b0;
    z = cur_slice;
    n = (box_limit > MAX_BOXES) ? MAX_BOXES : box_limit;
    if (overlay_on) begin
      for (i = 0; i < n && !hit; i++) begin
        z0 = box_table[i].first_slice;
        z1 = box_table[i].last_slice;
        if (z >= z0 && z <= z1)
          hit = on_box_edge(box_table[i], w.pix_x, w.pix_y);
      end
    end
    if (hit) begin
      rgb.red = HIT_RED;
      rgb.green = HIT_GREEN;
      rgb.blue = HIT_BLUE;
      rgb.outline_hit = 1'b1;
    end else begin
      rgb.red = g;
      rgb.green = g;
      rgb.blue = g;
      rgb.outline_hit = 1'b0;
    end
    return rgb;
  endfunction

  // word with random filler in the fields the kind does not use
  function automatic in_word_t junk_word();
    logic [159:0] bits;
    in_word_t w;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = bits[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t pixel_word(int hu, int x, int y);
    in_word_t w;
    w = junk_word();
    w.req_type = REQ_PIXEL;
    w.hu = 16'(hu);
    w.pix_x = 12'(x);
    w.pix_y = 12'(y);
    return w;
  endfunction

  function automatic in_word_t load_word(int slot, int x0, int y0, int x1, int y1,
                                         int z0, int z1);
    in_word_t w;
    w = junk_word();
    w.req_type = REQ_LOAD;
    w.box_index = 4'(slot);
    w.box_x0 = 16'(x0);
    w.box_y0 = 16'(y0);
    w.box_x1 = 16'(x1);
    w.box_y1 = 16'(y1);
    w.box_z0 = 16'(z0);
    w.box_z1 = 16'(z1);
    return w;
  endfunction

  // mostly small boxes near the pixels, some inverted or fully random
  function automatic in_word_t random_load(int slot);
    int x0, y0, x1, y1, z0, z1, roll;
    roll = $urandom_range(99);
    x0 = $urandom_range(48);
    y0 = $urandom_range(48);
    x1 = x0 + $urandom_range(16);
    y1 = y0 + $urandom_range(16);
    z0 = int'($urandom_range(40)) - 8;
    z1 = z0 + $urandom_range(40);
    if (roll < 10) begin
      x0 = x1 + 1 + $urandom_range(4);
    end else if (roll < 20) begin
      x0 = $urandom;
      y0 = $urandom;
      x1 = $urandom;
      y1 = $urandom;
    end
    if ($urandom_range(99) < 10) begin
      z0 = -32768;
      z1 = 32767;
    end else if ($urandom_range(99) < 10) begin
      z0 = $urandom;
      z1 = $urandom;
    end
    return load_word(slot, x0, y0, x1, y1, z0, z1);
  endfunction

  // random traffic: some loads, many pixels aimed at active outlines
  function automatic in_word_t random_word();
    int roll, hu, x, y, n, slot, x0, y0, x1, y1, tx, ty;
    box_t b;
    roll = $urandom_range(99);
    if (roll < 15) return random_load($urandom_range(MAX_BOXES - 1));
    if ($urandom_range(99) < 40)
      hu = $urandom;
    else
      hu = int'(win_min) + int'($urandom_range(2 * window_span)) - window_span / 4;
    x = $urandom_range(70);
    y = $urandom_range(70);
    if (roll < 25) begin
      x = $urandom_range(MAX_IMAGE_DIM - 1);
      y = $urandom_range(MAX_IMAGE_DIM - 1);
    end else if (roll < 80) begin
      n = (box_limit > MAX_BOXES) ? MAX_BOXES : box_limit;
      slot = (n == 0) ? $urandom_range(MAX_BOXES - 1) : $urandom_range(n - 1);
      b = box_table[slot];
      x0 = b.left;
      y0 = b.top;
      x1 = b.right;
      y1 = b.bottom;
      tx = x0;
      ty = y0;
      if (x0 <= x1 && y0 <= y1) begin
        if ($urandom_range(1)) begin
          tx = x0 + $urandom_range(x1 - x0);
          ty = $urandom_range(1) ? y0 : y1;
        end else begin
          ty = y0 + $urandom_range(y1 - y0);
          tx = $urandom_range(1) ? x0 : x1;
        end
      end
      // near misses just off the outline
      if ($urandom_range(99) < 20) begin
        tx = tx + int'($urandom_range(2)) - 1;
        ty = ty + int'($urandom_range(2)) - 1;
      end
      if (tx >= 0 && tx < MAX_IMAGE_DIM && ty >= 0 && ty < MAX_IMAGE_DIM) begin
        x = tx;
        y = ty;
      end
    end
    return pixel_word(hu, x, y);
  endfunction

  // register write, shadow copy follows the written value
  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_WINDOW_MIN:     win_min = value[15:0];
      CFG_WINDOW_GAIN:    win_gain = value;
      CFG_SLICE_Z:        cur_slice = value[11:0];
      CFG_BOX_COUNT:      box_limit = value[4:0];
      CFG_OVERLAY_ENABLE: overlay_on = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one word, wait for the handshake, then update the prediction
  task automatic send_word(in_word_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if (w.req_type == REQ_LOAD) begin
      box_table[w.box_index].left = w.box_x0;
      box_table[w.box_index].top = w.box_y0;
      box_table[w.box_index].right = w.box_x1;
      box_table[w.box_index].bottom = w.box_y1;
      box_table[w.box_index].first_slice = w.box_z0;
      box_table[w.box_index].last_slice = w.box_z1;
    end else begin
      rgb_due.push_back(shade_pixel(w));
    end
  endtask

  // stop sending until every pixel is out and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // defaults after reset, intensity extremes, writes past the register list
  task automatic test_reset_values();
    int k;
    send_word(pixel_word(-32768, 0, 0));
    send_word(pixel_word(-1, 4095, 4095));
    send_word(pixel_word(0, 1, 2));
    send_word(pixel_word(1, 3, 4));
    send_word(pixel_word(100, 5, 6));
    send_word(pixel_word(32767, 7, 8));
    drain();
    for (k = int'(CFG_OVERLAY_ENABLE) + 1; k < 2 ** CFG_INDEX_W; k++)
      write_reg(CFG_INDEX_W'(k), '1);
    send_word(pixel_word(255, 0, 0));
    send_word(pixel_word(8000, 4095, 0));
    drain();
  endtask

  // hand-placed boxes: plain, inverted, full-range, out of slice
  task automatic test_outline_cases();
    send_word(load_word(0, 10, 20, 30, 40, 0, 5));
    send_word(load_word(1, 50, 60, 40, 50, 0, 5));
    send_word(load_word(2, -32768, -32768, 32767, 0, -32768, 32767));
    send_word(load_word(3, 100, 100, 110, 110, 200, 300));
    drain();
    write_reg(CFG_WINDOW_MIN, 32'(-1024));
    write_reg(CFG_WINDOW_GAIN, 32'd8160);
    write_reg(CFG_SLICE_Z, 32'd3);
    write_reg(CFG_BOX_COUNT, 32'd4);
    write_reg(CFG_OVERLAY_ENABLE, 32'd1);
    send_word(pixel_word(0, 15, 20));
    send_word(pixel_word(1023, 30, 40));
    send_word(pixel_word(-1024, 15, 25));
    send_word(pixel_word(-1025, 10, 30));
    send_word(pixel_word(500, 50, 60));
    send_word(pixel_word(-500, 4095, 0));
    send_word(pixel_word(200, 0, 4095));
    send_word(pixel_word(300, 100, 105));
    send_word(pixel_word(-32768, 31, 40));
    drain();
    // overlay off, then no boxes in use
    write_reg(CFG_OVERLAY_ENABLE, 32'd0);
    send_word(pixel_word(0, 15, 20));
    drain();
    write_reg(CFG_OVERLAY_ENABLE, 32'd1);
    write_reg(CFG_BOX_COUNT, 32'd0);
    send_word(pixel_word(0, 15, 20));
    drain();
  endtask

  // every slot gets written before any box count can reach it
  task automatic test_fill_table();
    int slot;
    for (slot = 0; slot < MAX_BOXES; slot++)
      send_word(random_load(slot));
    drain();
  endtask

  // random phases, each with its own settings and idling mode
  task automatic test_random_traffic();
    int phase, i, wmin, gain, slice, count;
    for (phase = 0; phase < 8; phase++) begin
      window_span = 1 + $urandom_range(3000);
      wmin = int'($urandom_range(4000)) - 2000;
      gain = (255 * 65536) / window_span;
      slice = $urandom_range(50);
      count = $urandom_range(31);
      if (phase == 2) wmin = -32768;
      if (phase == 5) wmin = 32767;
      if (phase == 7) wmin = $urandom;
      if (phase == 3) gain = 0;
      if (phase == 6) gain = 32'hFFFF_FFFF;
      if (phase == 4) slice = MAX_IMAGE_DIM - 1;
      if (phase == 1) count = 0;
      if (phase == 3) count = MAX_BOXES;
      if (phase == 7) count = 31;
      write_reg(CFG_WINDOW_MIN, {16'($urandom), 16'(wmin)});
      write_reg(CFG_WINDOW_GAIN, 32'(gain));
      write_reg(CFG_SLICE_Z, {20'($urandom), 12'(slice)});
      write_reg(CFG_BOX_COUNT, {27'($urandom), 5'(count)});
      write_reg(CFG_OVERLAY_ENABLE, {31'($urandom), (phase != 0)});
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 69; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 69; end
        default: begin send_idle_pct = 19; recv_idle_pct = 19; end
      endcase
      for (i = 0; i < 80; i++)
        send_word(random_word());
      drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    int i;
    write_reg(CFG_BOX_COUNT, MAX_BOXES);
    write_reg(CFG_OVERLAY_ENABLE, 32'd1);
    long_hold_req = 1'b1;
    for (i = 0; i < 40; i++)
      send_word(random_word());
    drain();
  endtask

  // receiver stall, with one long hold on request
  initial begin : stall_gen
    int held;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        for (held = 0; held < LONG_HOLD; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= SHOWN_ERRORS)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // compare each output word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_due.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("unexpected output word %h", out_word);
      end else begin
        want_rgb = rgb_due.pop_front();
        check_field("red", want_rgb.red, out_word.red);
        check_field("green", want_rgb.green, out_word.green);
        check_field("blue", want_rgb.blue, out_word.blue);
        check_field("outline_hit", 8'(want_rgb.outline_hit), 8'(out_word.outline_hit));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // reset, then the tests in turn
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_outline_cases();
    test_fill_table();
    test_random_traffic();
    test_backpressure();
    if (error_count == 0 && rgb_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
design/wlbo_pkg.sv
design/window_level_box_overlay_core.sv
tb/tb_window_level_box_overlay_core.sv
